// ===== hdl/kbd_pkg.sv =====
// Shared types, constants and key tables for the scan-code set 1 decoder.
// Used by kbd_lookup and keyboard_scancode_decoder; depends on nothing.
`timescale 1ns / 1ps

package kbd_pkg;

   // Size of the pressed-key set and the widths that follow from it.
   localparam int PRESSED_SLOTS = 8;
   localparam int SLOT_W = (PRESSED_SLOTS > 1) ? $clog2(PRESSED_SLOTS) : 1;
   localparam int CNT_W  = $clog2(PRESSED_SLOTS + 1);

   // Prefix bytes and the prefix state codes.
   localparam logic [7:0] BYTE_E0 = 8'hE0;
   localparam logic [7:0] BYTE_E1 = 8'hE1;
   localparam logic [1:0] PFX_NONE = 2'd0;
   localparam logic [1:0] PFX_E0   = 2'd1;
   localparam logic [1:0] PFX_E1   = 2'd2;

   // Scan codes with a special meaning.
   localparam logic [6:0] SC_LSHIFT = 7'd42;
   localparam logic [6:0] SC_RSHIFT = 7'd54;
   localparam logic [6:0] SC_ALT    = 7'd56;
   localparam logic [6:0] SC_CTRL   = 7'd29;
   localparam logic [6:0] SC_CAPS   = 7'd58;
   localparam logic [6:0] SC_SCROLL = 7'd70;
   localparam logic [6:0] SC_NUM    = 7'd69;
   localparam logic [6:0] SC_PAD7   = 7'd71;
   localparam logic [6:0] SC_DEL    = 7'd83;
   localparam logic [6:0] SC_SLASH  = 7'd53;
   localparam logic [6:0] SC_DIV    = 7'd8;

   // Bit positions in the modifier and lock flag words.
   localparam int MB_SHIFT = 0;
   localparam int MB_ALTL  = 1;
   localparam int MB_ALTR  = 2;
   localparam int MB_CTRLL = 3;
   localparam int MB_CTRLR = 4;
   localparam int LB_SCROLL = 0;
   localparam int LB_NUM    = 1;
   localparam int LB_CAPS   = 2;

   // Context that steers the character lookup.
   typedef struct packed {
      logic e0;
      logic no_prefix;
      logic numlk_on;
      logic capslk_on;
      logic shift;
      logic altr_held;
   } kbd_ctx_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } kbd_state_type;

   // Unshifted German layout.
   function automatic logic [7:0] plain_chr(input logic [6:0] c);
      logic [7:0] r;
      case (c)
         7'd2: r = 8'd49;   7'd3: r = 8'd50;   7'd4: r = 8'd51;   7'd5: r = 8'd52;
         7'd6: r = 8'd53;   7'd7: r = 8'd54;   7'd8: r = 8'd55;   7'd9: r = 8'd56;
         7'd10: r = 8'd57;  7'd11: r = 8'd48;  7'd12: r = 8'd225; 7'd13: r = 8'd39;
         7'd14: r = 8'd8;   7'd16: r = 8'd113; 7'd17: r = 8'd119; 7'd18: r = 8'd101;
         7'd19: r = 8'd114; 7'd20: r = 8'd116; 7'd21: r = 8'd122; 7'd22: r = 8'd117;
         7'd23: r = 8'd105; 7'd24: r = 8'd111; 7'd25: r = 8'd112; 7'd26: r = 8'd129;
         7'd27: r = 8'd43;  7'd28: r = 8'd10;  7'd30: r = 8'd97;  7'd31: r = 8'd115;
         7'd32: r = 8'd100; 7'd33: r = 8'd102; 7'd34: r = 8'd103; 7'd35: r = 8'd104;
         7'd36: r = 8'd106; 7'd37: r = 8'd107; 7'd38: r = 8'd108; 7'd39: r = 8'd148;
         7'd40: r = 8'd132; 7'd41: r = 8'd94;  7'd43: r = 8'd35;  7'd44: r = 8'd121;
         7'd45: r = 8'd120; 7'd46: r = 8'd99;  7'd47: r = 8'd118; 7'd48: r = 8'd98;
         7'd49: r = 8'd110; 7'd50: r = 8'd109; 7'd51: r = 8'd44;  7'd52: r = 8'd46;
         7'd53: r = 8'd45;  7'd55: r = 8'd42;  7'd57: r = 8'd32;  7'd74: r = 8'd45;
         7'd78: r = 8'd43;  7'd86: r = 8'd60;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   // Shifted German layout.
   function automatic logic [7:0] upper_chr(input logic [6:0] c);
      logic [7:0] r;
      case (c)
         7'd2: r = 8'd33;   7'd3: r = 8'd34;   7'd4: r = 8'd21;   7'd5: r = 8'd36;
         7'd6: r = 8'd37;   7'd7: r = 8'd38;   7'd8: r = 8'd47;   7'd9: r = 8'd40;
         7'd10: r = 8'd41;  7'd11: r = 8'd61;  7'd12: r = 8'd63;  7'd13: r = 8'd96;
         7'd16: r = 8'd81;  7'd17: r = 8'd87;  7'd18: r = 8'd69;  7'd19: r = 8'd82;
         7'd20: r = 8'd84;  7'd21: r = 8'd90;  7'd22: r = 8'd85;  7'd23: r = 8'd73;
         7'd24: r = 8'd79;  7'd25: r = 8'd80;  7'd26: r = 8'd154; 7'd27: r = 8'd42;
         7'd30: r = 8'd65;  7'd31: r = 8'd83;  7'd32: r = 8'd68;  7'd33: r = 8'd70;
         7'd34: r = 8'd71;  7'd35: r = 8'd72;  7'd36: r = 8'd74;  7'd37: r = 8'd75;
         7'd38: r = 8'd76;  7'd39: r = 8'd153; 7'd40: r = 8'd142; 7'd41: r = 8'd248;
         7'd43: r = 8'd39;  7'd44: r = 8'd89;  7'd45: r = 8'd88;  7'd46: r = 8'd67;
         7'd47: r = 8'd86;  7'd48: r = 8'd66;  7'd49: r = 8'd78;  7'd50: r = 8'd77;
         7'd51: r = 8'd59;  7'd52: r = 8'd58;  7'd53: r = 8'd95;  7'd57: r = 8'd32;
         7'd86: r = 8'd62;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   // Characters reached with right alt.
   function automatic logic [7:0] altgr_chr(input logic [6:0] c);
      logic [7:0] r;
      case (c)
         7'd3: r = 8'd253;  7'd8: r = 8'd123;  7'd9: r = 8'd91;   7'd10: r = 8'd93;
         7'd11: r = 8'd125; 7'd12: r = 8'd92;  7'd16: r = 8'd64;  7'd27: r = 8'd126;
         7'd50: r = 8'd230; 7'd86: r = 8'd124;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   // Keypad with num lock: character and remapped scan code, offset from code 71.
   function automatic logic [14:0] pad_entry(input logic [3:0] i);
      logic [14:0] r;
      case (i)
         4'd0: r = {8'd55, 7'd8};   4'd1: r = {8'd56, 7'd9};   4'd2: r = {8'd57, 7'd10};
         4'd3: r = {8'd45, 7'd53};  4'd4: r = {8'd52, 7'd5};   4'd5: r = {8'd53, 7'd6};
         4'd6: r = {8'd54, 7'd7};   4'd7: r = {8'd43, 7'd27};  4'd8: r = {8'd49, 7'd2};
         4'd9: r = {8'd50, 7'd3};   4'd10: r = {8'd51, 7'd4};  4'd11: r = {8'd48, 7'd11};
         4'd12: r = {8'd44, 7'd51};
         default: r = 15'd0;
      endcase
      return r;
   endfunction

   function automatic logic is_letter(input logic [6:0] c);
      return c inside {[7'd16:7'd26], [7'd30:7'd40], [7'd44:7'd50]};
   endfunction

endpackage

// ===== hdl/kbd_lookup.sv =====
// Character lookup for a completed make code in the German layout.
// Depends on kbd_pkg for the tables and the lookup context.
`timescale 1ns / 1ps

module kbd_lookup (
   input  kbd_pkg::kbd_ctx_type ctx,
   input  logic [6:0]           code,
   output logic [7:0]           ascii,
   output logic [6:0]           scan
);
   import kbd_pkg::*;

   logic [3:0]  pad_off;
   logic [14:0] pad;

   assign pad_off = 4'(code - SC_PAD7);
   assign pad     = pad_entry(pad_off);

   // Priority: keypad divide, keypad with num lock, right alt, shift, caps letters, plain.
   always_comb begin
      scan = code;
      if (code == SC_SLASH && ctx.e0) begin
         ascii = 8'd47;
         scan  = SC_DIV;
      end else if (ctx.numlk_on && ctx.no_prefix && code >= SC_PAD7 && code <= SC_DEL) begin
         ascii = pad[14:7];
         scan  = pad[6:0];
      end else if (ctx.altr_held) begin
         ascii = altgr_chr(code);
      end else if (ctx.shift || (ctx.capslk_on && is_letter(code))) begin
         ascii = upper_chr(code);
      end else begin
         ascii = plain_chr(code);
      end
   end

endmodule

// ===== hdl/keyboard_scancode_decoder.sv =====
// Scan-code set 1 keyboard decoder: top level with the pressed-key memory walk.
// Depends on kbd_pkg and kbd_lookup.
`timescale 1ns / 1ps

// Takes one keyboard byte per request (tdata = scan byte, tuser = byte came from the
// mouse port and is ignored) and returns one result per request. A byte that needs
// no pressed-key bookkeeping (prefix, code zero, auxiliary) goes straight to the finish
// state; a make or break code walks the pressed-key memory one slot per cycle through
// its single read port and stops early when the code is found. The memory's valid
// bits clear at reset, so no clearing pass is needed. A new request is taken as soon
// as the previous result sits in the output register.
module keyboard_scancode_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] scan_byte
   input  logic        req_tuser,   // [0] from_aux
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] key_valid, [8:1] ascii, [15:9] scancode, [16] shift, [17] left alt held,
   // [18] right alt held, [19] left ctrl held, [20] right ctrl held, [23:21] lock_leds,
   // [24] led_update, [28:25] keys_down, [29] reboot_request, [31:30] zero
   output logic [31:0] rsp_tdata
);
   import kbd_pkg::*;

   kbd_state_type state_ff, state_in;
   logic [7:0]  byte_ff, byte_in;
   logic        aux_ff, aux_in;

   // Walk control.
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic [SLOT_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic              match_ff, match_in;
   logic [SLOT_W-1:0] match_idx_ff, match_idx_in;
   logic              free_ff, free_in;
   logic [SLOT_W-1:0] free_idx_ff, free_idx_in;

   // Pressed-key memory.
   logic [6:0]               set_mem_ff [PRESSED_SLOTS];
   logic [PRESSED_SLOTS-1:0] slot_vld_ff;
   logic [SLOT_W-1:0]        rd_addr;
   logic [6:0]               rd_data_ff;
   logic                     rd_vld_ff;
   logic                     wr_en;
   logic [SLOT_W-1:0]        wr_addr;
   logic [6:0]               wr_data;
   logic [6:0]               entry;

   // Decoder state.
   logic [1:0]       prefix_ff, prefix_in;
   logic [4:0]       mods_ff, mods_in;
   logic [2:0]       locks_ff, locks_in;
   logic [7:0]       last_ascii_ff, last_ascii_in;
   logic [6:0]       last_scan_ff, last_scan_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0] rsp_tdata_ff, rsp_tdata_in;

   logic        accept, out_free, need_walk, e0, key_valid, led_chg, reboot;
   logic [6:0]  code, lk_scan;
   logic [7:0]  lk_ascii;
   kbd_ctx_type ctx;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign code       = byte_ff[6:0];
   assign e0         = (prefix_ff == PFX_E0);
   assign need_walk  = !req_tuser && req_tdata != BYTE_E0 && req_tdata != BYTE_E1 &&
                       req_tdata[6:0] != 7'd0;
   assign entry      = rd_vld_ff ? rd_data_ff : 7'd0;

   assign ctx = '{e0: e0, no_prefix: (prefix_ff == PFX_NONE), numlk_on: locks_ff[LB_NUM],
                  capslk_on: locks_ff[LB_CAPS], shift: mods_ff[MB_SHIFT],
                  altr_held: mods_ff[MB_ALTR]};

   kbd_lookup u_lookup (
      .ctx   (ctx),
      .code  (code),
      .ascii (lk_ascii),
      .scan  (lk_scan)
   );

   // Sequencer: accept, walk the memory for make and break codes, then commit state and load the result.
   always_comb begin
      state_in     = state_ff;
      byte_in      = byte_ff;
      aux_in       = aux_ff;
      issue_in     = issue_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_vld_in   = 1'b0;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      rd_addr      = issue_ff[SLOT_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               byte_in  = req_tdata;
               aux_in   = req_tuser;
               issue_in = '0;
               match_in = 1'b0;
               free_in  = 1'b0;
               state_in = need_walk ? S_SCAN : S_FINISH;
            end
         end
         S_SCAN: begin
            if (issue_ff < CNT_W'(PRESSED_SLOTS)) begin
               issue_in   = issue_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[SLOT_W-1:0];
            end
            if (cmp_vld_ff) begin
               if (entry == code) begin
                  match_in     = 1'b1;
                  match_idx_in = cmp_idx_ff;
                  state_in     = S_FINISH;
               end else begin
                  if (entry == 7'd0 && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = cmp_idx_ff;
                  end
                  if (cmp_idx_ff == SLOT_W'(PRESSED_SLOTS - 1)) state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Byte decode; its effect is committed in the finishing cycle.
   always_comb begin
      prefix_in     = prefix_ff;
      mods_in       = mods_ff;
      locks_in      = locks_ff;
      last_ascii_in = last_ascii_ff;
      last_scan_in  = last_scan_ff;
      count_in      = count_ff;
      key_valid     = 1'b0;
      led_chg       = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = free_idx_ff;
      wr_data       = code;
      if (!aux_ff) begin
         if (byte_ff == BYTE_E0) begin
            prefix_in = PFX_E0;
         end else if (byte_ff == BYTE_E1) begin
            prefix_in = PFX_E1;
         end else if (byte_ff[7]) begin
            if (code == SC_LSHIFT || code == SC_RSHIFT) mods_in[MB_SHIFT] = 1'b0;
            else if (code == SC_ALT) mods_in[e0 ? MB_ALTR : MB_ALTL] = 1'b0;
            else if (code == SC_CTRL) mods_in[e0 ? MB_CTRLR : MB_CTRLL] = 1'b0;
            prefix_in = PFX_NONE;
            if (match_ff) begin
               wr_en    = 1'b1;
               wr_addr  = match_idx_ff;
               wr_data  = 7'd0;
               if (count_ff != '0) count_in = count_ff - 1'b1;
            end
         end else begin
            if (code == SC_LSHIFT || code == SC_RSHIFT) begin
               mods_in[MB_SHIFT] = 1'b1;
            end else if (code == SC_ALT) begin
               mods_in[e0 ? MB_ALTR : MB_ALTL] = 1'b1;
            end else if (code == SC_CTRL) begin
               mods_in[e0 ? MB_CTRLR : MB_CTRLL] = 1'b1;
            end else if (code == SC_CAPS) begin
               locks_in[LB_CAPS] = !locks_ff[LB_CAPS];
               led_chg = 1'b1;
            end else if (code == SC_SCROLL) begin
               locks_in[LB_SCROLL] = !locks_ff[LB_SCROLL];
               led_chg = 1'b1;
            end else if (code == SC_NUM && !mods_ff[MB_CTRLL]) begin
               locks_in[LB_NUM] = !locks_ff[LB_NUM];
               led_chg = 1'b1;
            end else begin
               last_ascii_in = lk_ascii;
               last_scan_in  = lk_scan;
               key_valid     = 1'b1;
            end
            prefix_in = PFX_NONE;
            if (!match_ff && free_ff) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
      end
      reboot = key_valid && (mods_in[MB_CTRLL] || mods_in[MB_CTRLR]) &&
               (mods_in[MB_ALTL] || mods_in[MB_ALTR]) && last_scan_in == SC_DEL;
      rsp_tdata_in = {2'b00, reboot, 4'(count_in), led_chg, locks_in, mods_in,
                      last_scan_in, last_ascii_in, key_valid};
   end

   // Output register handshake.
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (state_ff == S_FINISH && out_free) rsp_tvalid_in = 1'b1;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cmp_vld_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         prefix_ff     <= PFX_NONE;
         mods_ff       <= '0;
         locks_ff      <= '0;
         last_ascii_ff <= '0;
         last_scan_ff  <= '0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (state_ff == S_FINISH && out_free) begin
            prefix_ff     <= prefix_in;
            mods_ff       <= mods_in;
            locks_ff      <= locks_in;
            last_ascii_ff <= last_ascii_in;
            last_scan_ff  <= last_scan_in;
            count_ff      <= count_in;
         end
      end
   end

   // Payload registers of the walk and the result.
   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      aux_ff       <= aux_in;
      issue_ff     <= issue_in;
      cmp_idx_ff   <= cmp_idx_in;
      match_ff     <= match_in;
      match_idx_ff <= match_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      if (state_ff == S_FINISH && out_free) rsp_tdata_ff <= rsp_tdata_in;
   end

   // Pressed-key memory: one registered read, one write in the finishing cycle.
   always_ff @(posedge clock) begin
      rd_data_ff <= set_mem_ff[rd_addr];
      if (wr_en && state_ff == S_FINISH && out_free) set_mem_ff[wr_addr] <= wr_data;
   end

   // Entry valid bits; an entry never written reads as a free slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         rd_vld_ff <= slot_vld_ff[rd_addr];
         if (wr_en && state_ff == S_FINISH && out_free) slot_vld_ff[wr_addr] <= 1'b1;
      end
   end

   // The set count never exceeds the number of slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(PRESSED_SLOTS))
      else $error("pressed-key count exceeds the slot count");

   // A reboot flag only comes with a completed key.
   a_reboot_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[29] |-> rsp_tdata[0])
      else $error("reboot flag without a completed key");

   // A completed key and an LED update never come from the same byte.
   a_key_led: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[24]))
      else $error("key and LED update on one byte");

   // An accepted request moves the sequencer out of idle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == S_SCAN || state_ff == S_FINISH)
      else $error("request accepted but sequencer stayed idle");

endmodule
